// File: src/tcw_pkg.sv
// shared types and constants for the text console writer
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_BLANK     = 8'h20;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;
  localparam logic [15:0] CELL_RESET   = {ATTR_RESET, CH_BLANK};

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_word_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic        scrolled;
  } rsp_word_t;

endpackage

// File: src/tcw_ram.sv
// generic single write port, single read port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/text_console_writer_top.sv
// text console writer: screen ram, cursor and scroll sequencer
// a put or read executes in the exec state; its result is loaded into the response word
// once the sink is free, and no new word is taken until then; a put that scrolls adds a
// copy pass moving each row up by one and a blanking pass of the last row, bounded
// by the one-entry-per-cycle read/modify/write through the screen ram
// one item is in work at a time; the next is accepted while a result waits for its sink
// synchronous reset starts a clearing pass over the COLS*ROWS cells (2000 at 80x25) that
// fills the screen with blank cells in attribute 7; items are stalled until it ends
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req_word,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp_word
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_BLANK,
    S_RESP
  } state_t;

  state_t      state;
  logic [CW-1:0] sc;
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [7:0]  attr;
  req_word_t   req_q;
  logic        in_range_q;
  logic [15:0] res_cell;
  logic        res_scr;

  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  logic [7:0]    col_inc;
  logic [5:0]    line_inc;
  logic [6:0]    col_next;
  logic [5:0]    line_next;
  logic          scroll_need;
  logic          is_nl;
  logic          is_bs;
  logic [AW-1:0] row_base;
  logic          req_take;
  logic          rsp_free;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    is_nl       = (req_q.char_code == CH_NEWLINE);
    is_bs       = (req_q.char_code == CH_BACKSPACE);
    col_inc     = {1'b0, cur_col} + 8'd1;
    line_inc    = {1'b0, cur_row} + 6'd1;
    row_base    = AW'(cur_row * COLS);
    col_next    = cur_col;
    line_next   = {1'b0, cur_row};
    if (is_nl) begin
      col_next  = 7'd0;
      line_next = line_inc;
    end else if (is_bs) begin
      if (cur_col != 7'd0) begin
        col_next = cur_col - 7'd1;
      end
    end else if (col_inc == 8'(COLS)) begin
      col_next  = 7'd0;
      line_next = line_inc;
    end else begin
      col_next  = col_inc[6:0];
    end
    scroll_need = (line_next == 6'(ROWS));

    mem_we  = 1'b0;
    wr_addr = AW'(sc);
    wr_data = {attr, CH_BLANK};
    rd_addr = AW'(req_word.cell_index);
    case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_data = CELL_RESET;
      end
      S_EXEC: begin
        if (req_q.kind == KIND_PUT && !is_nl) begin
          if (is_bs) begin
            mem_we  = (cur_col != 7'd0);
            wr_addr = row_base + AW'(cur_col - 7'd1);
          end else begin
            mem_we  = 1'b1;
            wr_addr = row_base + AW'(cur_col);
            wr_data = {attr, req_q.char_code};
          end
        end
      end
      S_COPY: begin
        rd_addr = AW'(sc + CW'(COLS));
        mem_we  = (sc != '0);
        wr_addr = AW'(sc - CW'(1));
        wr_data = rd_data;
      end
      S_BLANK: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sc        <= '0;
      cur_col   <= 7'd0;
      cur_row   <= 5'd0;
      attr      <= ATTR_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sc == CW'(CELLS - 1)) begin
            sc    <= '0;
            state <= S_IDLE;
          end else begin
            sc <= sc + CW'(1);
          end
        end
        S_IDLE: begin
          if (req_take) begin
            req_q      <= req_word;
            in_range_q <= (13'(req_word.cell_index) < 13'(CELLS));
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_scr  <= (req_q.kind == KIND_PUT) && scroll_need;
          res_cell <= (req_q.kind == KIND_READ && in_range_q) ? rd_data : 16'd0;
          if (req_q.kind == KIND_READ) begin
            state <= S_RESP;
          end else begin
            cur_col <= col_next;
            if (scroll_need) begin
              cur_row <= 5'(ROWS - 1);
              sc      <= '0;
              state   <= S_COPY;
            end else begin
              cur_row <= line_next[4:0];
              state   <= S_RESP;
            end
          end
        end
        S_COPY: begin
          if (sc == CW'(CELLS - COLS)) begin
            sc    <= CW'((ROWS - 1) * COLS);
            state <= S_BLANK;
          end else begin
            sc <= sc + CW'(1);
          end
        end
        S_BLANK: begin
          if (sc == CW'(CELLS - 1)) begin
            state <= S_RESP;
          end else begin
            sc <= sc + CW'(1);
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp_word.cell_value <= res_cell;
            rsp_word.cursor_col <= cur_col;
            rsp_word.cursor_row <= cur_row;
            rsp_word.cursor_pos <= 11'(cur_row * COLS + cur_col);
            rsp_word.scrolled   <= res_scr;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("accepted word did not enter execution");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_row} < 6'(ROWS))
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_col} < 8'(COLS))
    else $error("cursor column out of range");

  a_copy_ports: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY && mem_we |-> wr_addr != rd_addr)
    else $error("scroll copy reads and writes the same cell");

  a_resp_load: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && rsp_free |=> rsp_valid && state == S_IDLE)
    else $error("result not loaded");

endmodule
